// ----- rtl/ldss_pkg.sv -----
// ----------------------------------------------------------------------------
// ldss_pkg
// Types and constants shared by the LED driver serial sequencer modules.
// ----------------------------------------------------------------------------
package ldss_pkg;

    localparam int DC_W        = 6;    // dot correction word width
    localparam int GS_W        = 12;   // grayscale word width
    localparam int CH_IDX_W    = 5;    // channel index width
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_DOT_CORRECTION   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRAY_CLOCK_COUNT = 2'd1;

    localparam logic [DC_W-1:0] DC_RESET         = 6'd63;
    localparam logic [GS_W-1:0] GRAY_COUNT_RESET = 12'd4095;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [2:0] {
        PH_DC_SHIFT  = 3'd0,
        PH_DC_LATCH  = 3'd1,
        PH_GS_SHIFT  = 3'd2,
        PH_GS_LATCH  = 3'd3,
        PH_GRAY      = 3'd4,
        PH_BLANK_ON  = 3'd5,
        PH_BLANK_OFF = 3'd6
    } phase_t;

    // pin levels of one step, serial_data in bit 0
    typedef struct packed {
        logic blank_pin;
        logic gray_pulse;
        logic program_mode;
        logic latch_pulse;
        logic shift_pulse;
        logic serial_data;
    } pins_t;

endpackage

// ----- rtl/ldss_core.sv -----
// ----------------------------------------------------------------------------
// ldss_core
// Sequencer state, channel store, frame shift register and pin decode.
// ----------------------------------------------------------------------------
module ldss_core #(
    parameter int CHANNELS = 27
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_accept,
    input  logic                             item_op,
    input  logic [ldss_pkg::CH_IDX_W-1:0]    item_channel,
    input  logic [ldss_pkg::GS_W-1:0]        item_level,
    input  logic                             cfg_we,
    input  logic [ldss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ldss_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ldss_pkg::pins_t                  result
);
    import ldss_pkg::*;

    localparam int DC_BITS = CHANNELS * DC_W;
    localparam int GS_DATA = CHANNELS * GS_W;
    localparam int GS_PAD  = (8 - (GS_DATA % 8)) % 8;
    localparam int GS_BITS = GS_DATA + GS_PAD;
    localparam int CNT_W   = $clog2(GS_BITS + 1);

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [2:0]         dc_pos_reg, dc_pos_next;
    logic [GS_W-1:0]    gray_cnt_reg, gray_cnt_next;
    logic               blank_reg, blank_next;
    logic [GS_BITS-1:0] snap_reg, snap_next;
    logic [GS_W-1:0]    store_reg [CHANNELS];
    logic [DC_W-1:0]    dc_reg;
    logic [GS_W-1:0]    gray_limit_reg;

    logic [GS_BITS-1:0] store_flat;
    logic [CNT_W-1:0]   bit_cnt_inc;
    logic [GS_W:0]      gray_inc;
    logic [GS_W-1:0]    gray_limit;
    logic               is_tick;
    logic               ch_valid;

    assign is_tick     = item_accept && (item_op == OP_TICK);
    assign ch_valid    = {1'b0, item_channel} < (CH_IDX_W + 1)'(CHANNELS);
    assign bit_cnt_inc = bit_cnt_reg + 1'b1;
    assign gray_inc    = {1'b0, gray_cnt_reg} + 1'b1;
    assign gray_limit  = (gray_limit_reg == '0) ? GS_W'(1) : gray_limit_reg;

    // pad bits on top, then highest channel down to channel 0
    always_comb
    begin
        store_flat = '0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            store_flat[ch*GS_W +: GS_W] = store_reg[ch];
        end
    end

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        dc_pos_next   = dc_pos_reg;
        gray_cnt_next = gray_cnt_reg;
        blank_next    = blank_reg;
        snap_next     = snap_reg;
        if (is_tick)
        begin
            case (phase_reg)
                PH_DC_SHIFT:
                begin
                    dc_pos_next  = (dc_pos_reg == 3'(DC_W - 1)) ? 3'd0 : dc_pos_reg + 3'd1;
                    bit_cnt_next = bit_cnt_inc;
                    if (bit_cnt_inc >= CNT_W'(DC_BITS))
                    begin
                        bit_cnt_next = '0;
                        phase_next   = PH_DC_LATCH;
                    end
                end
                PH_DC_LATCH:
                begin
                    bit_cnt_next = '0;
                    phase_next   = PH_GS_SHIFT;
                end
                PH_GS_SHIFT:
                begin
                    // first bit of the frame takes the snapshot
                    if (bit_cnt_reg == '0)
                        snap_next = store_flat << 1;
                    else
                        snap_next = snap_reg << 1;
                    bit_cnt_next = bit_cnt_inc;
                    if (bit_cnt_inc >= CNT_W'(GS_BITS))
                    begin
                        bit_cnt_next = '0;
                        phase_next   = PH_GS_LATCH;
                    end
                end
                PH_GS_LATCH:
                begin
                    gray_cnt_next = '0;
                    phase_next    = PH_GRAY;
                end
                PH_GRAY:
                begin
                    gray_cnt_next = gray_inc[GS_W-1:0];
                    if (gray_inc >= {1'b0, gray_limit})
                    begin
                        gray_cnt_next = '0;
                        phase_next    = PH_BLANK_ON;
                    end
                end
                PH_BLANK_ON:
                begin
                    blank_next = 1'b0;
                    phase_next = PH_BLANK_OFF;
                end
                default:
                begin
                    blank_next   = 1'b1;
                    bit_cnt_next = '0;
                    phase_next   = PH_GS_SHIFT;
                end
            endcase
        end
    end

    // pin levels
    always_comb
    begin
        result              = '0;
        result.blank_pin    = blank_next;
        result.program_mode = (phase_reg == PH_DC_SHIFT) || (phase_reg == PH_DC_LATCH);
        if (is_tick)
        begin
            case (phase_reg)
                PH_DC_SHIFT:
                begin
                    result.shift_pulse = 1'b1;
                    result.serial_data = dc_reg[3'(DC_W - 1) - dc_pos_reg];
                end
                PH_DC_LATCH:
                    result.latch_pulse = 1'b1;
                PH_GS_SHIFT:
                begin
                    result.shift_pulse = 1'b1;
                    result.serial_data = (bit_cnt_reg == '0) ? store_flat[GS_BITS-1]
                                                             : snap_reg[GS_BITS-1];
                end
                PH_GS_LATCH:
                    result.latch_pulse = 1'b1;
                PH_GRAY:
                    result.gray_pulse = 1'b1;
                default:
                    result.serial_data = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_DC_SHIFT;
            bit_cnt_reg  <= '0;
            dc_pos_reg   <= '0;
            gray_cnt_reg <= '0;
            blank_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            dc_pos_reg   <= dc_pos_next;
            gray_cnt_reg <= gray_cnt_next;
            blank_reg    <= blank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                store_reg[ch] <= '0;
            end
        end
        else if (item_accept && (item_op == OP_WRITE) && ch_valid)
        begin
            store_reg[item_channel] <= item_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg         <= DC_RESET;
            gray_limit_reg <= GRAY_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DOT_CORRECTION:   dc_reg         <= cfg_data[DC_W-1:0];
                CFG_GRAY_CLOCK_COUNT: gray_limit_reg <= cfg_data[GS_W-1:0];
                default:              dc_reg         <= dc_reg;
            endcase
        end
    end

endmodule

// ----- rtl/ldss_out_buf.sv -----
// ----------------------------------------------------------------------------
// ldss_out_buf
// Output register with a skid stage; input ready comes from a register.
// ----------------------------------------------------------------------------
module ldss_out_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ldss_pkg::pins_t in_pins,
    output logic            out_valid,
    input  logic            out_ready,
    output ldss_pkg::pins_t out_pins
);
    import ldss_pkg::*;

    logic  out_valid_reg;
    logic  skid_valid_reg;
    pins_t out_pins_reg;
    pins_t skid_pins_reg;
    logic  in_xfer;
    logic  out_free;

    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_pins  = out_pins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_xfer;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_pins_reg <= skid_pins_reg;
            else if (in_xfer)
                out_pins_reg <= in_pins;
        end
        else if (in_xfer)
        begin
            skid_pins_reg <= in_pins;
        end
    end

endmodule

// ----- rtl/led_driver_serial_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// led_driver_serial_sequencer_unit
// Pin sequencer for a daisy-chained 12-bit grayscale LED driver chain.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | tuser operation, tdata channel, level
//  m_      | out | m_tvalid/m_tready | tdata pin levels of one step
//  cfg_    | in  | cfg_valid/ready   | cfg_index, cfg_data (always ready)
//
//  One transfer in, one transfer out; one item per cycle sustained while m_tready stays high.
//  The pin levels of an accepted item go to the output register, or to the skid stage while it stalls.
//  s_tready is registered: it drops only when the skid stage holds a result.
//  After reset the dot correction shift runs first; the channel store reads
//  zero and the sequencer needs no clearing pass.
// ----------------------------------------------------------------------------
module led_driver_serial_sequencer_unit #(
    parameter int CHANNELS = 27
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // channel[4:0], level[16:5]
    input  logic                             s_tuser,   // operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // serial_data, shift_pulse,
                                                        // latch_pulse, program_mode,
                                                        // gray_pulse, blank_pin
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ldss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ldss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ldss_pkg::*;

    pins_t core_pins;
    pins_t out_pins;
    logic  s_xfer;

    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_tdata   = {2'b00, out_pins};

    ldss_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_accept  (s_xfer),
        .item_op      (s_tuser),
        .item_channel (s_tdata[CH_IDX_W-1:0]),
        .item_level   (s_tdata[CH_IDX_W +: GS_W]),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (core_pins)
    );

    ldss_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pins   (core_pins),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pins  (out_pins)
    );

endmodule

// ----- tb/sv/led_driver_serial_sequencer_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_driver_serial_sequencer_unit_test
// Self-checking bench for the LED driver pin sequencer. A scoreboard class
// predicts the pin levels of every step. It covers the dot correction shift,
// the grayscale frames, channel writes and blanking. The stream sides idle
// and stall at random, and both registers go through several settings.
// ----------------------------------------------------------------------------
module led_driver_serial_sequencer_unit_test;

    import ldss_pkg::*;

    localparam int CHAIN_CHANNELS = 27;
    localparam int DC_BITS        = CHAIN_CHANNELS * 6;
    localparam int GS_DATA_BITS   = CHAIN_CHANNELS * 12;
    localparam int GS_PAD         = (8 - (GS_DATA_BITS % 8)) % 8;
    localparam int GS_BITS        = GS_DATA_BITS + GS_PAD;
    localparam int CYCLE_LIMIT    = 600000;

    class sequencer_pin_board;
        logic [GS_W-1:0] store [CHAIN_CHANNELS];
        logic [GS_W-1:0] snap [CHAIN_CHANNELS];
        phase_t          ph;
        int unsigned     bit_cnt;
        int unsigned     gray_cnt;
        logic            blank;
        logic [DC_W-1:0] dc_word;
        logic [GS_W-1:0] gray_limit;
        pins_t           pins_due[$];
        int unsigned     pin_mismatches;
        int unsigned     orphan_results;
        int unsigned     checked;
        int unsigned     ticks;
        int unsigned     writes;
        int unsigned     ghost_writes;
        int unsigned     frames;

        function new();
            foreach (store[i])
            begin
                store[i] = '0;
                snap[i]  = '0;
            end
            ph         = PH_DC_SHIFT;
            bit_cnt    = 0;
            gray_cnt   = 0;
            blank      = 1'b0;
            dc_word    = DC_RESET;
            gray_limit = GRAY_COUNT_RESET;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_DOT_CORRECTION)
                dc_word = val[DC_W-1:0];
            else if (idx == CFG_GRAY_CLOCK_COUNT)
                gray_limit = val;
        endfunction

        // pad bits first, then channels from the top down, MSB first
        function logic frame_bit(int unsigned k);
            int unsigned j;
            int unsigned ch;
            int unsigned b;
            if (k < GS_PAD)
                return 1'b0;
            j  = k - GS_PAD;
            ch = CHAIN_CHANNELS - 1 - j / 12;
            b  = 11 - j % 12;
            return snap[ch][b];
        endfunction

        function void note_item(logic op, logic [CH_IDX_W-1:0] ch, logic [GS_W-1:0] lvl);
            pins_t       p;
            int unsigned limit;
            p = '0;
            if (op == OP_WRITE)
            begin
                writes++;
                if (ch < CHAIN_CHANNELS)
                    store[ch] = lvl;
                else
                    ghost_writes++;
                p.program_mode = (ph == PH_DC_SHIFT || ph == PH_DC_LATCH);
            end
            else
            begin
                ticks++;
                case (ph)
                    PH_DC_SHIFT:
                    begin
                        p.program_mode = 1'b1;
                        p.shift_pulse  = 1'b1;
                        p.serial_data  = dc_word[5 - bit_cnt % 6];
                        bit_cnt++;
                        if (bit_cnt >= DC_BITS)
                        begin
                            bit_cnt = 0;
                            ph      = PH_DC_LATCH;
                        end
                    end
                    PH_DC_LATCH:
                    begin
                        p.program_mode = 1'b1;
                        p.latch_pulse  = 1'b1;
                        bit_cnt        = 0;
                        ph             = PH_GS_SHIFT;
                    end
                    PH_GS_SHIFT:
                    begin
                        if (bit_cnt == 0)
                            snap = store;
                        p.shift_pulse = 1'b1;
                        p.serial_data = frame_bit(bit_cnt);
                        bit_cnt++;
                        if (bit_cnt >= GS_BITS)
                        begin
                            bit_cnt = 0;
                            ph      = PH_GS_LATCH;
                        end
                    end
                    PH_GS_LATCH:
                    begin
                        p.latch_pulse = 1'b1;
                        gray_cnt      = 0;
                        ph            = PH_GRAY;
                    end
                    PH_GRAY:
                    begin
                        p.gray_pulse = 1'b1;
                        // a zero count still gives one pulse
                        limit = (gray_limit == '0) ? 1 : gray_limit;
                        gray_cnt++;
                        if (gray_cnt >= limit)
                        begin
                            gray_cnt = 0;
                            ph       = PH_BLANK_ON;
                        end
                    end
                    PH_BLANK_ON:
                    begin
                        blank = 1'b0;
                        ph    = PH_BLANK_OFF;
                    end
                    default:
                    begin
                        blank   = 1'b1;
                        bit_cnt = 0;
                        ph      = PH_GS_SHIFT;
                        frames++;
                    end
                endcase
            end
            p.blank_pin = blank;
            pins_due.push_back(p);
        endfunction

        function void check_pins(logic [7:0] got);
            pins_t want;
            if (pins_due.size() == 0)
            begin
                orphan_results++;
                if (orphan_results + pin_mismatches <= 10)
                    $display("unexpected result transfer, tdata %b", got);
                return;
            end
            want = pins_due.pop_front();
            checked++;
            if (got !== {2'b00, want})
            begin
                pin_mismatches++;
                if (orphan_results + pin_mismatches <= 10)
                    $display({"result %0d: expected sd %b sp %b lp %b pm %b gp %b bl %b,",
                              " got sd %b sp %b lp %b pm %b gp %b bl %b pad %b"},
                             checked, want.serial_data, want.shift_pulse, want.latch_pulse,
                             want.program_mode, want.gray_pulse, want.blank_pin,
                             got[0], got[1], got[2], got[3], got[4], got[5], got[7:6]);
            end
        endfunction

        function int unsigned pending();
            return pins_due.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [23:0]            s_tdata;    // channel[4:0], level[16:5]
    logic                   s_tuser;    // operation
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;    // serial_data, shift_pulse, latch_pulse,
                                        // program_mode, gray_pulse, blank_pin
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sequencer_pin_board board;
    logic               quiet;
    int unsigned        cycles;

    led_driver_serial_sequencer_unit #(
        .CHANNELS (CHAIN_CHANNELS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // transfers are recorded at the rising edge, before the block updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_pins(m_tdata);
            if (s_tvalid && s_tready)
                board.note_item(s_tuser, s_tdata[4:0], s_tdata[16:5]);
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[led_driver_serial_sequencer_unit] ERROR");
            $finish;
        end
    end

    // result sink: random stall before each transfer
    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_item(logic op, logic [CH_IDX_W-1:0] ch, logic [GS_W-1:0] lvl);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {7'd0, lvl, ch};
        do @(posedge clk); while (!s_tready);
    endtask

    // hold the input side until every predicted step has come out
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (2) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_phase(int unsigned count);
        logic [CH_IDX_W-1:0] ch;
        logic [GS_W-1:0]     lvl;
        logic                op;
        int unsigned         n;
        int unsigned         pick;
        for (n = 0; n < count; n++)
        begin
            if (n % 48 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == count / 2)
                wait_drained();
            op   = ($urandom_range(0, 99) < 15) ? OP_WRITE : OP_TICK;
            ch   = CH_IDX_W'($urandom_range(0, 31));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                lvl = '0;
            else if (pick == 1)
                lvl = '1;
            else
                lvl = GS_W'($urandom_range(0, 4095));
            send_item(op, ch, lvl);
        end
    endtask

    initial
    begin
        logic [DC_W-1:0] dc_mix;
        logic [5:0]      junk;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_TICK;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DOT_CORRECTION;
        cfg_data  = '0;
        quiet     = 1'b0;
        cycles    = 0;
        board     = new();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // a mixed word so the dot correction stream carries both levels;
        // upper data bits are don't-care for this register
        dc_mix = DC_W'($urandom_range(1, 62));
        junk   = 6'($urandom_range(0, 63));
        set_reg(CFG_DOT_CORRECTION, {junk, dc_mix});
        set_reg(CFG_GRAY_CLOCK_COUNT, 12'd2);

        // writes at the channel and level extremes, writes past the chain
        send_item(OP_WRITE, 5'd0, 12'hFFF);
        send_item(OP_WRITE, 5'd26, 12'hFFF);
        send_item(OP_WRITE, 5'd13, 12'hA5A);
        send_item(OP_WRITE, 5'd27, 12'hFFF);
        send_item(OP_WRITE, 5'd31, 12'h123);
        send_item(OP_WRITE, 5'd1, 12'h000);
        send_item(OP_WRITE, 5'd25, 12'h801);
        send_item(OP_TICK, 5'd31, 12'hFFF);
        send_item(OP_TICK, 5'd0, 12'h000);
        send_item(OP_WRITE, 5'd26, 12'h000);
        send_item(OP_WRITE, 5'd26, 12'h7FE);
        send_item(OP_TICK, 5'd27, 12'h555);
        send_item(OP_TICK, 5'd5, 12'hAAA);

        run_phase(380);
        set_reg(CFG_DOT_CORRECTION, 12'd0);
        set_reg(CFG_GRAY_CLOCK_COUNT, 12'd1);
        run_phase(300);
        set_reg(CFG_DOT_CORRECTION, 12'd63);
        set_reg(CFG_GRAY_CLOCK_COUNT, 12'd0);
        run_phase(260);
        set_reg(CFG_GRAY_CLOCK_COUNT, 12'd4095);
        run_phase(450);
        // a small count may land below a count already reached
        set_reg(CFG_GRAY_CLOCK_COUNT, 12'($urandom_range(2, 9)));
        run_phase(140);

        wait_drained();
        repeat (4) @(posedge clk);
        $display("ran %0d ticks and %0d channel writes (%0d past the chain) over %0d frames",
                 board.ticks, board.writes, board.ghost_writes, board.frames);
        $display("checked %0d steps: %0d mismatches, %0d unexpected, %0d missing",
                 board.checked, board.pin_mismatches, board.orphan_results, board.pending());
        if (board.pin_mismatches == 0 && board.orphan_results == 0 && board.pending() == 0)
            $display("[led_driver_serial_sequencer_unit] OK");
        else
            $display("[led_driver_serial_sequencer_unit] ERROR");
        $finish;
    end

endmodule
